// ===== design/mtsc_pkg.sv =====
// shared types and constants for the multi toggle switch counter
// no dependencies; used by multi_toggle_switch_counter
`default_nettype none

package mtsc_pkg;

  // switches that can be handled at most, one bit each in the input item
  localparam int MAX_LANES = 8;
  localparam int NUM_SWITCHES_DEF = 8;

  localparam int CNT_W = 3;
  localparam int TMR_W = 4;
  localparam int SW_IDX_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CNT_W-1:0] COUNT_LIMIT_RST = 3'd4;
  localparam logic [TMR_W-1:0] TIMEOUT_RST = 4'd15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

  // item kinds carried in tuser
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_CAPTURE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [SW_IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic level;
  } evt_t;

  typedef struct packed {
    logic stall;
    logic commit;
    logic load_mid;
    logic load_last;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== design/multi_toggle_switch_counter.sv =====
// multi toggle switch counter: top level with lane state and sequencer
// depends on mtsc_pkg
`default_nettype none

// Counts toggle sequences on up to eight switches. A tick item (tuser = 0)
// carries the sampled levels in tdata; a capture item (tuser = 1) loads the
// levels as settled state and clears all counts and timers as it is taken.
// A tick is worked through by one shared lane update unit, one switch per
// cycle unless stalled, for min(NUM_SWITCHES, 8) switches; a flush state then
// hands the final event to the output register and the block returns to idle
// before the next item is taken. Back-pressure on the output stalls the walk
// when an event is found while another is held back and the output register
// is full, and holds the flush state likewise. Events leave in rising switch
// order, tlast marking the final one of the tick. The input is not ready
// while a tick is being worked through.
module multi_toggle_switch_counter #(
  parameter int NUM_SWITCHES = mtsc_pkg::NUM_SWITCHES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  // input items
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] switch_levels
  input  wire logic s_tuser,         // [0] func
  // result items
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [7:0] m_tdata,        // [2:0] switch_index, [5:3] toggle_count, [6] level, [7] zero
  output logic m_tlast,
  // configuration
  input  wire logic cfg_we,
  input  wire logic [mtsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mtsc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LANES = (NUM_SWITCHES < mtsc_pkg::MAX_LANES) ?
                         NUM_SWITCHES : mtsc_pkg::MAX_LANES;
  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CNT_W = mtsc_pkg::CNT_W;
  localparam int TMR_W = mtsc_pkg::TMR_W;

  mtsc_pkg::state_t state, state_next;
  mtsc_pkg::ctrl_t ctrl;

  logic [CNT_W-1:0] count_limit;
  logic [TMR_W-1:0] timeout_ticks;

  logic             settled [LANES];
  logic [CNT_W-1:0] change_count [LANES];
  logic [TMR_W-1:0] tick_timer [LANES];

  logic [LANES-1:0] levels;
  logic [IDX_W-1:0] idx;

  logic           pend_valid;
  mtsc_pkg::evt_t pend;
  mtsc_pkg::evt_t out_evt;

  // shared lane update unit
  logic             live, held, changed, lane_idle, fire, out_free, last_lane;
  logic [CNT_W-1:0] cnt, cnt_upd;
  logic [TMR_W-1:0] tmr, tmr_upd;
  mtsc_pkg::evt_t   new_evt;

  logic accept;

  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign last_lane = (idx == IDX_W'(LANES - 1));

  always_comb begin
    live = levels[idx];
    held = settled[idx];
    cnt = change_count[idx];
    tmr = tick_timer[idx];
    // odd count: back at the settled level counts as a change
    changed = cnt[0] ? (live == held) : (live != held);
    lane_idle = (cnt == '0) && (tmr == '0) && (live == held);
    if (changed) begin
      cnt_upd = cnt + CNT_W'(1);
      tmr_upd = '0;
    end else if (cnt != '0) begin
      cnt_upd = cnt;
      tmr_upd = tmr + TMR_W'(1);
    end else begin
      cnt_upd = cnt;
      tmr_upd = tmr;
    end
    fire = !lane_idle && ((cnt_upd >= count_limit) || (tmr_upd >= timeout_ticks));
    new_evt.idx = mtsc_pkg::SW_IDX_W'(idx);
    new_evt.cnt = cnt_upd;
    new_evt.level = live;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mtsc_pkg::ST_IDLE: begin
        if (accept && s_tuser == mtsc_pkg::FUNC_TICK) begin
          state_next = mtsc_pkg::ST_BUSY;
        end
      end
      mtsc_pkg::ST_BUSY: begin
        if (ctrl.commit && last_lane) begin
          state_next = mtsc_pkg::ST_FLUSH;
        end
      end
      mtsc_pkg::ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = mtsc_pkg::ST_IDLE;
        end
      end
      default: state_next = mtsc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = 1'b0;
    ctrl = '0;
    unique case (state)
      mtsc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      mtsc_pkg::ST_BUSY: begin
        // a second event needs the waiting one moved out first
        ctrl.stall = fire && pend_valid && !out_free;
        ctrl.commit = !ctrl.stall;
        ctrl.load_mid = ctrl.commit && fire && pend_valid;
      end
      mtsc_pkg::ST_FLUSH: begin
        ctrl.load_last = pend_valid && out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit <= mtsc_pkg::COUNT_LIMIT_RST;
      timeout_ticks <= mtsc_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtsc_pkg::CFG_COUNT_LIMIT: count_limit <= cfg_data[CNT_W-1:0];
        mtsc_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TMR_W-1:0];
        default: count_limit <= count_limit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      idx <= '0;
    end else if (ctrl.commit && !last_lane) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      levels <= s_tdata[LANES-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        settled[i] <= 1'b0;
        change_count[i] <= '0;
        tick_timer[i] <= '0;
      end
    end else if (accept && s_tuser == mtsc_pkg::FUNC_CAPTURE) begin
      for (int i = 0; i < LANES; i++) begin
        settled[i] <= s_tdata[i];
        change_count[i] <= '0;
        tick_timer[i] <= '0;
      end
    end else if (ctrl.commit && !lane_idle) begin
      if (fire) begin
        settled[idx] <= live;
        change_count[idx] <= '0;
        tick_timer[idx] <= '0;
      end else begin
        change_count[idx] <= cnt_upd;
        tick_timer[idx] <= tmr_upd;
      end
    end
  end

  // one event is held back until it is known whether another follows
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (ctrl.commit && fire) begin
      pend_valid <= 1'b1;
    end else if (ctrl.load_last) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit && fire) begin
      pend <= new_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.load_mid || ctrl.load_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_mid || ctrl.load_last) begin
      out_evt <= pend;
      m_tlast <= ctrl.load_last;
    end
  end

  assign m_tdata = {1'b0, out_evt.level, out_evt.cnt, out_evt.idx};

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !pend_valid)
    else $error("input ready while an event is still held back");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    ctrl.stall |=> (state == mtsc_pkg::ST_BUSY) && $stable(idx))
    else $error("sequencer moved on during an output stall");

  a_fire_pends: assert property (@(posedge clk) disable iff (rst)
    (ctrl.commit && fire) |=> pend_valid)
    else $error("fired event not held");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (ctrl.load_mid || ctrl.load_last) |-> (out_free && pend_valid))
    else $error("output register overwritten");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (state == mtsc_pkg::ST_FLUSH && state_next == mtsc_pkg::ST_IDLE) |=> !pend_valid)
    else $error("event left behind at end of tick");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for multi_toggle_switch_counter
// keeps its own model of the switch toggle state and checks every event item
// depends on mtsc_pkg and the multi_toggle_switch_counter rtl
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_PHASES = 6;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic func;
    logic [7:0] levels;
  } switch_item_t;

  typedef struct packed {
    logic [mtsc_pkg::SW_IDX_W-1:0] sw_idx;
    logic [mtsc_pkg::CNT_W-1:0] count;
    logic level;
    logic last;
  } toggle_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;  // [7:0] switch_levels
  logic s_tuser = 1'b0;      // [0] func
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;       // [2:0] switch_index, [5:3] toggle_count, [6] level, [7] zero
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [mtsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mtsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  multi_toggle_switch_counter dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // switch state as the block should hold it
  logic settled [8];
  logic [mtsc_pkg::CNT_W-1:0] changes [8];
  logic [mtsc_pkg::TMR_W-1:0] idle_ticks [8];
  logic [mtsc_pkg::CNT_W-1:0] limit_reg = mtsc_pkg::COUNT_LIMIT_RST;
  logic [mtsc_pkg::TMR_W-1:0] timeout_reg = mtsc_pkg::TIMEOUT_RST;

  switch_item_t items_to_send[$];
  toggle_event_t events_due[$];
  logic [7:0] gen_levels = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  bit item_taken = 0;
  int failures = 0;
  int items_taken = 0;
  int captures_taken = 0;
  int events_checked = 0;
  int longest_burst = 0;

  task automatic track_toggles(input logic func, input logic [7:0] levels);
    toggle_event_t fired [8];
    int n_fired;
    logic live;
    logic changed;
    logic [mtsc_pkg::CNT_W-1:0] c;
    logic [mtsc_pkg::TMR_W-1:0] t;
    n_fired = 0;
    if (func == mtsc_pkg::FUNC_CAPTURE) begin
      for (int s = 0; s < 8; s++) begin
        settled[s] = levels[s];
        changes[s] = '0;
        idle_ticks[s] = '0;
      end
      return;
    end
    for (int s = 0; s < 8; s++) begin
      live = levels[s];
      c = changes[s];
      t = idle_ticks[s];
      // odd count: returning to the settled level is the next change
      changed = c[0] ? (live == settled[s]) : (live != settled[s]);
      if (c == '0 && t == '0 && live == settled[s])
        continue;
      if (changed) begin
        c = c + 1'b1;
        t = '0;
      end else if (c != '0) begin
        t = t + 1'b1;
      end
      if (c >= limit_reg || t >= timeout_reg) begin
        fired[n_fired] = '{sw_idx: s[mtsc_pkg::SW_IDX_W-1:0], count: c, level: live,
                           last: 1'b0};
        n_fired++;
        settled[s] = live;
        changes[s] = '0;
        idle_ticks[s] = '0;
      end else begin
        changes[s] = c;
        idle_ticks[s] = t;
      end
    end
    if (n_fired > 0)
      fired[n_fired-1].last = 1'b1;
    for (int i = 0; i < n_fired; i++)
      events_due.push_back(fired[i]);
    if (n_fired > longest_burst)
      longest_burst = n_fired;
  endtask

  task automatic check_event();
    toggle_event_t want;
    if (events_due.size() == 0) begin
      $error("event item with none due: tdata %h tlast %b", m_tdata, m_tlast);
      failures++;
    end else begin
      want = events_due.pop_front();
      events_checked++;
      if (m_tdata[2:0] !== want.sw_idx) begin
        $error("switch_index: expected %0d, got %0d", want.sw_idx, m_tdata[2:0]);
        failures++;
      end
      if (m_tdata[5:3] !== want.count) begin
        $error("toggle_count: expected %0d, got %0d", want.count, m_tdata[5:3]);
        failures++;
      end
      if (m_tdata[6] !== want.level) begin
        $error("level: expected %0d, got %0d", want.level, m_tdata[6]);
        failures++;
      end
      if (m_tlast !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, m_tlast);
        failures++;
      end
    end
  endtask

  always @(posedge clk) begin
    item_taken = !rst && s_tvalid && s_tready;
    if (item_taken) begin
      track_toggles(s_tuser, s_tdata);
      items_taken++;
      if (s_tuser == mtsc_pkg::FUNC_CAPTURE)
        captures_taken++;
    end
    if (!rst && m_tvalid && m_tready)
      check_event();
  end

  // sender: keeps tvalid up until the item is taken
  always @(negedge clk) begin
    switch_item_t next_item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || item_taken) begin
      if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = items_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= next_item.func;
        s_tdata <= next_item.levels;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off whenever one is asked for
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_item(input logic func, input logic [7:0] levels);
    items_to_send.push_back('{func: func, levels: levels});
    gen_levels = levels;
  endtask

  // mostly small flips from the last levels so that counts build up and
  // time out; a few captures and wholly random ticks mixed in
  task automatic queue_random(input int n);
    int r;
    int flip_pct;
    logic [7:0] flips;
    flip_pct = 15;
    for (int i = 0; i < n; i++) begin
      if (i % 10 == 0) begin
        case ($urandom_range(2))
          0: flip_pct = 3;
          1: flip_pct = 15;
          default: flip_pct = 45;
        endcase
      end
      r = $urandom_range(99);
      if (r < 5) begin
        queue_item(mtsc_pkg::FUNC_CAPTURE, 8'($urandom_range(255)));
      end else if (r < 12) begin
        queue_item(mtsc_pkg::FUNC_TICK, 8'($urandom_range(255)));
      end else begin
        for (int b = 0; b < 8; b++)
          flips[b] = ($urandom_range(99) < flip_pct);
        queue_item(mtsc_pkg::FUNC_TICK, gen_levels ^ flips);
      end
    end
  endtask

  task automatic write_reg(input logic [mtsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mtsc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == mtsc_pkg::CFG_COUNT_LIMIT)
      limit_reg = val[mtsc_pkg::CNT_W-1:0];
    else
      timeout_reg = val[mtsc_pkg::TMR_W-1:0];
  endtask

  // a tick with no events may still be in flight, hence the settle time
  task automatic drain_block();
    while (items_to_send.size() != 0 || s_tvalid || events_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [mtsc_pkg::CFG_DATA_W-1:0] lim_w;
    logic [mtsc_pkg::CFG_DATA_W-1:0] tmo_w;
    for (int s = 0; s < 8; s++) begin
      settled[s] = 1'b0;
      changes[s] = '0;
      idle_ticks[s] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = (ph < 2) ? 24 : ((ph < 4) ? 48 : 0);
      recv_idle_pct = (ph < 2) ? 48 : ((ph < 4) ? 24 : 0);
      // zero and out-of-range settings included; 4'hf on the limit keeps 7
      case (ph)
        1: begin lim_w = 4'd2; tmo_w = 4'd3; end
        2: begin lim_w = 4'd1; tmo_w = 4'd1; end
        3: begin lim_w = 4'd0; tmo_w = 4'd15; end
        4: begin lim_w = 4'hf; tmo_w = 4'd0; end
        default: begin lim_w = 4'd4; tmo_w = 4'd15; end
      endcase
      if (ph > 0) begin
        write_reg(mtsc_pkg::CFG_COUNT_LIMIT, lim_w);
        write_reg(mtsc_pkg::CFG_TIMEOUT_TICKS, tmo_w);
      end
      if (ph == 0) begin
        // idle tick, capture high, four toggles on every switch, partial change
        queue_item(mtsc_pkg::FUNC_TICK, 8'h00);
        queue_item(mtsc_pkg::FUNC_CAPTURE, 8'hff);
        queue_item(mtsc_pkg::FUNC_TICK, 8'hff);
        queue_item(mtsc_pkg::FUNC_TICK, 8'h00);
        queue_item(mtsc_pkg::FUNC_TICK, 8'hff);
        queue_item(mtsc_pkg::FUNC_TICK, 8'h00);
        queue_item(mtsc_pkg::FUNC_TICK, 8'hff);
        queue_item(mtsc_pkg::FUNC_TICK, 8'h55);
        queue_item(mtsc_pkg::FUNC_CAPTURE, 8'h00);
        queue_item(mtsc_pkg::FUNC_TICK, 8'haa);
      end else if (ph == 1) begin
        // one switch times out, then two reach the limit in the same tick
        queue_item(mtsc_pkg::FUNC_CAPTURE, 8'h00);
        queue_item(mtsc_pkg::FUNC_TICK, 8'h01);
        queue_item(mtsc_pkg::FUNC_TICK, 8'h01);
        queue_item(mtsc_pkg::FUNC_TICK, 8'h01);
        queue_item(mtsc_pkg::FUNC_TICK, 8'h01);
        queue_item(mtsc_pkg::FUNC_TICK, 8'h02);
        queue_item(mtsc_pkg::FUNC_TICK, 8'h01);
      end
      if (ph == NUM_PHASES - 1)
        holds_asked++;
      queue_random((ph == 0) ? 30 : 40);
      drain_block();
    end
    $display("testbench: %0d items taken (%0d captures), %0d switch events checked",
             items_taken, captures_taken, events_checked);
    $display("testbench: %0d register settings, up to %0d events from one tick",
             NUM_PHASES, longest_burst);
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== multi_toggle_switch_counter.f =====
design/mtsc_pkg.sv
design/multi_toggle_switch_counter.sv
dv/testbench.sv
